>>> sv/bpfr_pkg.sv
// bpfr_pkg: shared types and constants of the bit pattern frequency ranker
// configuration register codes, reset values, sequencer states and the
// control structs between sequencer and scan unit; no dependencies
package bpfr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_LEN_W  = 4;
  localparam int GROUP_W    = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LEN     = 2'd0,
    CFG_MAX_LEN     = 2'd1,
    CFG_GROUP_LIMIT = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_LEN_W-1:0] MIN_LEN_RST     = 4'd1;
  localparam logic [CFG_LEN_W-1:0] MAX_LEN_RST     = 4'd12;
  localparam logic [GROUP_W-1:0]   GROUP_LIMIT_RST = 7'd10;
  localparam logic [GROUP_W-1:0]   GROUP_SAT       = 7'd127;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_SCAN_EQ,
    ST_SCAN_LOWER,
    ST_RESCAN,
    ST_SCAN_FINAL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [CFG_LEN_W-1:0] min_len;
    logic [CFG_LEN_W-1:0] max_len;
    logic [GROUP_W-1:0]   group_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic start;
    logic stop_second;
  } scan_ctl_t;

  typedef struct packed {
    logic done;
    logic hit1;
    logic hit2;
  } scan_stat_t;

endpackage

>>> sv/bpfr_if.sv
// bpfr_if: valid/ready channel interfaces of the bit pattern frequency ranker
// input request channel, ranked result channel and configuration write channel
// depends on bpfr_pkg for the configuration field widths
interface bpfr_in_if;
  logic valid;
  logic ready;
  logic op;
  logic bit_in;

  modport source (output valid, op, bit_in, input ready);
  modport sink   (input valid, op, bit_in, output ready);
  modport mon    (input valid, ready, op, bit_in);
endinterface

interface bpfr_out_if #(
  parameter int MAX_PATTERN_LEN = 12,
  parameter int COUNT_BITS      = 18
);
  localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);

  logic                       valid;
  logic                       ready;
  logic [COUNT_BITS-1:0]      frequency;
  logic [LEN_W-1:0]           pattern_len;
  logic [MAX_PATTERN_LEN-1:0] pattern_bits;
  logic                       group_end;
  logic                       done_res;

  modport source (output valid, frequency, pattern_len, pattern_bits, group_end, done_res,
                  input ready);
  modport sink   (input valid, frequency, pattern_len, pattern_bits, group_end, done_res,
                  output ready);
  modport mon    (input valid, ready, frequency, pattern_len, pattern_bits, group_end,
                  done_res);
endinterface

interface bpfr_cfg_if import bpfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

>>> sv/bpfr_ram.sv
// bpfr_ram: generic single-clock RAM, one write port and one registered read port
// no dependencies
module bpfr_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 8192,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/bpfr_scan.sv
// bpfr_scan: shared table scan unit, one count compared per cycle
// finds first and second entry equal to a count and the largest count below it
// depends on bpfr_pkg for the control structs
module bpfr_scan import bpfr_pkg::*; #(
  parameter int IDX_W      = 13,
  parameter int COUNT_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scan_ctl_t             ctl,
  input  logic [IDX_W:0]        from_idx,
  input  logic [COUNT_BITS-1:0] cmp_val,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [COUNT_BITS-1:0] rd_data,
  output scan_stat_t            stat,
  output logic [IDX_W-1:0]      hit_idx,
  output logic [COUNT_BITS-1:0] lower_max
);

  logic                  busy;
  logic                  pend;
  logic                  hit1;
  logic                  hit2;
  logic [IDX_W:0]        addr;
  logic [IDX_W-1:0]      pend_addr;
  logic [COUNT_BITS-1:0] cmp;
  logic                  stop;
  logic                  issue;
  logic                  finish;
  logic                  is_eq;
  logic                  is_low;

  // addr carries one extra bit so the end of the table is a plain bit test
  assign issue  = busy && !addr[IDX_W] && !(stop && hit2);
  assign finish = busy && !issue && !pend;
  assign is_eq  = pend && (rd_data == cmp);
  assign is_low = pend && (rd_data < cmp) && (rd_data > lower_max);

  assign rd_en   = issue;
  assign rd_addr = addr[IDX_W-1:0];
  assign stat    = '{done: finish, hit1: hit1, hit2: hit2};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      hit1 <= 1'b0;
      hit2 <= 1'b0;
    end else begin
      pend <= issue;
      if (ctl.start) begin
        busy <= 1'b1;
        hit1 <= 1'b0;
        hit2 <= 1'b0;
      end else begin
        if (finish) begin
          busy <= 1'b0;
        end
        if (is_eq) begin
          if (!hit1) begin
            hit1 <= 1'b1;
          end else begin
            hit2 <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= addr[IDX_W-1:0];
    if (ctl.start) begin
      addr      <= from_idx;
      cmp       <= cmp_val;
      stop      <= ctl.stop_second;
      lower_max <= '0;
    end else begin
      if (issue) begin
        addr <= addr + (IDX_W+1)'(1);
      end
      if (is_eq && !hit1) begin
        hit_idx <= pend_addr;
      end
      if (is_low) begin
        lower_max <= rd_data;
      end
    end
  end

endmodule

>>> sv/bpfr_ctrl.sv
// bpfr_ctrl: sequencer of the bit pattern frequency ranker
// table clearing, counter updates per pushed bit and the ranking scans per fetch
// depends on bpfr_pkg and on the interfaces in bpfr_if
module bpfr_ctrl import bpfr_pkg::*; #(
  parameter int MAX_PATTERN_LEN = 12,
  parameter int COUNT_BITS      = 18,
  localparam int IDX_W          = MAX_PATTERN_LEN + 1,
  localparam int LEN_W          = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  bpfr_in_if.sink               items,
  input  cfg_regs_t             cfg,
  input  logic                  out_free,
  output logic                  res_load,
  output logic [COUNT_BITS-1:0] res_freq,
  output logic [IDX_W-1:0]      res_idx,
  output logic                  res_end,
  output logic                  res_done,
  output logic                  mem_wr_en,
  output logic [IDX_W-1:0]      mem_wr_addr,
  output logic [COUNT_BITS-1:0] mem_wr_data,
  output logic                  mem_rd_en,
  output logic [IDX_W-1:0]      mem_rd_addr,
  input  logic [COUNT_BITS-1:0] mem_rd_data,
  output scan_ctl_t             scan_ctl,
  output logic [IDX_W:0]        scan_from,
  output logic [COUNT_BITS-1:0] scan_cmp,
  input  logic                  scan_rd_en,
  input  logic [IDX_W-1:0]      scan_rd_addr,
  input  scan_stat_t            scan_stat,
  input  logic [IDX_W-1:0]      scan_hit_idx,
  input  logic [COUNT_BITS-1:0] scan_lower_max
);

  localparam int LW = ((LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W) + 1;

  state_t state, state_next;

  logic [IDX_W-1:0]           clr_addr;
  logic [MAX_PATTERN_LEN-1:0] recent_bits;
  logic [LEN_W-1:0]           bits_seen;
  logic [LW-1:0]              push_len;
  logic [LW-1:0]              push_hi;
  logic                       push_pend;
  logic [IDX_W-1:0]           push_addr;
  logic [COUNT_BITS-1:0]      group_count;
  logic [IDX_W:0]             scan_index;
  logic [GROUP_W-1:0]         groups_done;

  logic                       accept;
  logic                       is_push;
  logic                       is_fetch;
  logic [MAX_PATTERN_LEN:0]   shifted;
  logic [LEN_W-1:0]           bits_seen_next;
  logic [LW-1:0]              lo_len;
  logic [LW-1:0]              hi_cfg;
  logic [LW-1:0]              seen_ext;
  logic [LW-1:0]              push_hi_next;
  logic                       push_issue;
  logic                       push_finish;
  logic [IDX_W-1:0]           push_rd_addr;
  logic [COUNT_BITS-1:0]      count_inc;
  logic                       exhausted;
  logic [GROUP_W-1:0]         gd_inc;
  logic                       eq_done;
  logic                       lower_done;
  logic                       rescan_done;
  logic                       final_done;
  logic                       hit_now;
  logic                       need_final;

  assign accept   = items.valid && items.ready;
  assign is_push  = accept && (items.op == OP_PUSH);
  assign is_fetch = accept && (items.op == OP_FETCH);

  assign shifted        = {recent_bits, items.bit_in};
  assign bits_seen_next = (bits_seen == LEN_W'(MAX_PATTERN_LEN)) ? bits_seen
                                                                : bits_seen + LEN_W'(1);

  // length window for this bit: clamp the registers, then limit to bits seen
  assign lo_len       = (cfg.min_len == '0) ? LW'(1) : LW'(cfg.min_len);
  assign hi_cfg       = (LW'(cfg.max_len) > LW'(MAX_PATTERN_LEN)) ? LW'(MAX_PATTERN_LEN)
                                                                  : LW'(cfg.max_len);
  assign seen_ext     = LW'(bits_seen_next);
  assign push_hi_next = (hi_cfg < seen_ext) ? hi_cfg : seen_ext;

  assign push_issue  = (state == ST_PUSH) && (push_len <= push_hi);
  assign push_finish = (state == ST_PUSH) && !push_issue && !push_pend;
  assign count_inc   = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + COUNT_BITS'(1);

  // table index of the window of length push_len: marker bit over the value bits
  always_comb begin
    push_rd_addr = '0;
    for (int b = 0; b < MAX_PATTERN_LEN; b++) begin
      push_rd_addr[b] = recent_bits[b] && (LW'(b) < push_len);
    end
    for (int b = 0; b < IDX_W; b++) begin
      if (LW'(b) == push_len) begin
        push_rd_addr[b] = 1'b1;
      end
    end
  end

  assign exhausted   = (groups_done >= cfg.group_limit);
  assign gd_inc      = (groups_done == GROUP_SAT) ? groups_done : groups_done + GROUP_W'(1);
  assign eq_done     = (state == ST_SCAN_EQ) && scan_stat.done;
  assign lower_done  = (state == ST_SCAN_LOWER) && scan_stat.done;
  assign rescan_done = (state == ST_RESCAN) && scan_stat.done;
  assign final_done  = (state == ST_SCAN_FINAL) && scan_stat.done;
  assign hit_now     = (eq_done || rescan_done) && scan_stat.hit1;
  // last pattern of a group that is not the last group: look for a lower count
  assign need_final  = hit_now && !scan_stat.hit2 && !(gd_inc >= cfg.group_limit);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == '1) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (is_push) begin
          state_next = ST_PUSH;
        end else if (is_fetch) begin
          state_next = exhausted ? ST_RESULT : ST_SCAN_EQ;
        end
      end
      ST_PUSH: begin
        if (push_finish) state_next = ST_IDLE;
      end
      ST_SCAN_EQ: begin
        if (scan_stat.done) begin
          if (!scan_stat.hit1) state_next = ST_SCAN_LOWER;
          else state_next = need_final ? ST_SCAN_FINAL : ST_RESULT;
        end
      end
      ST_SCAN_LOWER: begin
        if (scan_stat.done) begin
          state_next = (scan_lower_max == '0) ? ST_RESULT : ST_RESCAN;
        end
      end
      ST_RESCAN: begin
        if (scan_stat.done) state_next = need_final ? ST_SCAN_FINAL : ST_RESULT;
      end
      ST_SCAN_FINAL: begin
        if (scan_stat.done) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    items.ready = (state == ST_IDLE);
    res_load    = (state == ST_RESULT) && out_free;

    mem_wr_en   = (state == ST_CLEAR) || push_pend;
    mem_wr_addr = (state == ST_CLEAR) ? clr_addr : push_addr;
    mem_wr_data = (state == ST_CLEAR) ? '0 : count_inc;
    mem_rd_en   = push_issue || scan_rd_en;
    mem_rd_addr = (state == ST_PUSH) ? push_rd_addr : scan_rd_addr;

    scan_ctl  = '{start: 1'b0, stop_second: 1'b1};
    scan_from = '0;
    scan_cmp  = group_count;
    priority if (is_fetch && !exhausted) begin
      scan_ctl.start = 1'b1;
      scan_from      = scan_index;
    end else if (eq_done && !scan_stat.hit1) begin
      scan_ctl = '{start: 1'b1, stop_second: 1'b0};
    end else if (lower_done && (scan_lower_max != '0)) begin
      scan_ctl.start = 1'b1;
      scan_cmp       = scan_lower_max;
    end else if (need_final) begin
      scan_ctl = '{start: 1'b1, stop_second: 1'b0};
    end else begin
      scan_ctl.start = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      recent_bits <= '0;
      bits_seen   <= '0;
      push_pend   <= 1'b0;
      group_count <= '1;
      scan_index  <= '0;
      groups_done <= '0;
    end else begin
      state     <= state_next;
      push_pend <= push_issue;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      if (is_push) begin
        recent_bits <= shifted[MAX_PATTERN_LEN-1:0];
        bits_seen   <= bits_seen_next;
        group_count <= '1;
        scan_index  <= '0;
        groups_done <= '0;
      end
      if (lower_done && (scan_lower_max != '0)) begin
        group_count <= scan_lower_max;
      end
      if (hit_now) begin
        scan_index <= {1'b0, scan_hit_idx} + (IDX_W+1)'(1);
        if (!scan_stat.hit2) begin
          groups_done <= gd_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    push_addr <= push_rd_addr;
    if (is_push) begin
      push_len <= lo_len;
      push_hi  <= push_hi_next;
    end else if (push_issue) begin
      push_len <= push_len + LW'(1);
    end

    priority if ((is_fetch && exhausted) || (lower_done && (scan_lower_max == '0)) ||
                 (rescan_done && !scan_stat.hit1)) begin
      // nothing left: empty result flagged as finished
      res_freq <= '0;
      res_idx  <= '0;
      res_end  <= 1'b0;
      res_done <= 1'b1;
    end else if (hit_now) begin
      res_freq <= group_count;
      res_idx  <= scan_hit_idx;
      res_end  <= !scan_stat.hit2;
      res_done <= !scan_stat.hit2 && (gd_inc >= cfg.group_limit);
    end else if (final_done) begin
      res_done <= (scan_lower_max == '0);
    end else begin
      res_done <= res_done;
    end
  end

endmodule

>>> sv/bit_pattern_frequency_ranker_core.sv
// Bit pattern frequency ranker. A push request (op 0) shifts one bit into the history and
// bumps the saturating count of every window of length min_len..max_len that ends at it;
// a fetch request (op 1) returns the next pattern in order of descending count, then
// shorter length, then smaller value, over the group_limit highest distinct counts.
// After reset the count table (2^(MAX_PATTERN_LEN+1) entries, 8192 by default) is cleared
// one entry per cycle while items.ready stays low; configuration writes are taken
// throughout. While a push is worked items.ready is low; it counts at most
// MAX_PATTERN_LEN lengths, one read-modify-write per cycle on the single table memory.
// A fetch takes up to four table scans and none once the group limit is reached: a search
// at the current count, on a miss a search for the next lower count and a rescan for it,
// and on the last pattern of a group a search for the count below. Each scan reads one
// entry per cycle through the table's one read port into the shared compare unit; a scan
// for the next pattern of the same count stops as soon as a second match shows up. One
// request is worked at a time; a result waits in the output register.
// depends on bpfr_pkg, bpfr_if, bpfr_ram, bpfr_scan and bpfr_ctrl
module bit_pattern_frequency_ranker_core import bpfr_pkg::*; #(
  parameter int MAX_PATTERN_LEN = 12,
  parameter int COUNT_BITS      = 18
) (
  input  logic       clk,
  input  logic       rst,
  bpfr_in_if.sink    items,
  bpfr_out_if.source ranks,
  bpfr_cfg_if.sink   cfg
);

  localparam int IDX_W = MAX_PATTERN_LEN + 1;
  localparam int DEPTH = 1 << IDX_W;
  localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);

  cfg_regs_t             regs;
  logic                  out_free;
  logic                  res_load;
  logic [COUNT_BITS-1:0] res_freq;
  logic [IDX_W-1:0]      res_idx;
  logic                  res_end;
  logic                  res_done;
  logic                  mem_wr_en;
  logic [IDX_W-1:0]      mem_wr_addr;
  logic [COUNT_BITS-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [IDX_W-1:0]      mem_rd_addr;
  logic [COUNT_BITS-1:0] mem_rd_data;
  scan_ctl_t             scan_ctl;
  logic [IDX_W:0]        scan_from;
  logic [COUNT_BITS-1:0] scan_cmp;
  logic                  scan_rd_en;
  logic [IDX_W-1:0]      scan_rd_addr;
  scan_stat_t            scan_stat;
  logic [IDX_W-1:0]      scan_hit_idx;
  logic [COUNT_BITS-1:0] scan_lower_max;
  logic [LEN_W-1:0]           enc_len;
  logic [MAX_PATTERN_LEN-1:0] enc_bits;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{min_len: MIN_LEN_RST, max_len: MAX_LEN_RST, group_limit: GROUP_LIMIT_RST};
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MIN_LEN:     regs.min_len     <= cfg.data[CFG_LEN_W-1:0];
        CFG_MAX_LEN:     regs.max_len     <= cfg.data[CFG_LEN_W-1:0];
        CFG_GROUP_LIMIT: regs.group_limit <= cfg.data[GROUP_W-1:0];
        default: begin
          regs <= regs;
        end
      endcase
    end
  end

  bpfr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  bpfr_scan #(
    .IDX_W      (IDX_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .from_idx  (scan_from),
    .cmp_val   (scan_cmp),
    .rd_en     (scan_rd_en),
    .rd_addr   (scan_rd_addr),
    .rd_data   (mem_rd_data),
    .stat      (scan_stat),
    .hit_idx   (scan_hit_idx),
    .lower_max (scan_lower_max)
  );

  bpfr_ctrl #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
    .COUNT_BITS      (COUNT_BITS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .items          (items),
    .cfg            (regs),
    .out_free       (out_free),
    .res_load       (res_load),
    .res_freq       (res_freq),
    .res_idx        (res_idx),
    .res_end        (res_end),
    .res_done       (res_done),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data),
    .scan_ctl       (scan_ctl),
    .scan_from      (scan_from),
    .scan_cmp       (scan_cmp),
    .scan_rd_en     (scan_rd_en),
    .scan_rd_addr   (scan_rd_addr),
    .scan_stat      (scan_stat),
    .scan_hit_idx   (scan_hit_idx),
    .scan_lower_max (scan_lower_max)
  );

  // pattern length is the position of the marker bit, value is what lies below it
  always_comb begin
    enc_len = '0;
    for (int b = 1; b < IDX_W; b++) begin
      if (res_idx[b]) enc_len = LEN_W'(b);
    end
    for (int b = 0; b < MAX_PATTERN_LEN; b++) begin
      enc_bits[b] = res_idx[b] && (LEN_W'(b) < enc_len);
    end
  end

  assign out_free = !ranks.valid || ranks.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ranks.valid <= 1'b0;
    end else if (res_load) begin
      ranks.valid <= 1'b1;
    end else if (ranks.ready) begin
      ranks.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      ranks.frequency    <= res_freq;
      ranks.pattern_len  <= enc_len;
      ranks.pattern_bits <= enc_bits;
      ranks.group_end    <= res_end;
      ranks.done_res     <= res_done;
    end
  end

endmodule

>>> sv/bpfr_checker.sv
// bpfr_checker: port-level checks of the bit pattern frequency ranker
// bound to bit_pattern_frequency_ranker_core; watches the handshake and result ports
module bpfr_checker #(
  parameter int MAX_PATTERN_LEN = 12,
  parameter int COUNT_BITS      = 18,
  localparam int LEN_W          = $clog2(MAX_PATTERN_LEN + 1)
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COUNT_BITS-1:0] frequency,
  input logic [LEN_W-1:0]      pattern_len,
  input logic                  group_end,
  input logic                  done_res
);

  // a held result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // an accepted request makes the block busy and drops ready
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an accepted request");

  // table clearing follows reset, no request taken then
  a_clear_after_rst: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !in_ready)
    else $error("request taken during table clearing");

  // an empty count means the empty finished answer, real patterns have a length
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((frequency == '0) == (pattern_len == '0)))
    else $error("count and pattern length disagree");

  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frequency == '0) |-> done_res && !group_end)
    else $error("empty result not flagged as finished");

endmodule

bind bit_pattern_frequency_ranker_core bpfr_checker #(
  .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
  .COUNT_BITS      (COUNT_BITS)
) u_bpfr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .out_valid   (ranks.valid),
  .out_ready   (ranks.ready),
  .frequency   (ranks.frequency),
  .pattern_len (ranks.pattern_len),
  .group_end   (ranks.group_end),
  .done_res    (ranks.done_res)
);
